// ----- hw/rtl/tvg_pkg.sv -----
package tvg_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_INNER_RADIUS    = 3'd0;
  localparam logic [2:0] CFG_OUTER_RADIUS    = 3'd1;
  localparam logic [2:0] CFG_RING_PHASE_STEP = 3'd2;
  localparam logic [2:0] CFG_SIDE_PHASE_STEP = 3'd3;

  // Taylor coefficients of sin(pi/2 * x), unsigned Q30
  localparam logic [63:0] C1 = 64'd1686629713;
  localparam logic [63:0] C3 = 64'd693598669;
  localparam logic [63:0] C5 = 64'd85569306;
  localparam logic [63:0] C7 = 64'd5026994;
  localparam logic [63:0] C9 = 64'd172273;

  // One vertex: position and normal, signed Q2.14
  typedef struct packed {
    logic signed [15:0] norm_z;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_x;
    logic signed [15:0] pos_z;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_x;
  } vertex_t;

  // Quarter-wave sine entry k of 2^addr_bits, Q14, evaluated at elaboration
  function automatic logic [14:0] sine_entry(int unsigned k, int unsigned addr_bits);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] p;
    u  = 64'(k) << (30 - addr_bits);
    u2 = (u * u) >> 30;
    p  = C9;
    p  = C7 - ((u2 * p) >> 30);
    p  = C5 - ((u2 * p) >> 30);
    p  = C3 - ((u2 * p) >> 30);
    p  = C1 - ((u2 * p) >> 30);
    p  = (u * p) >> 30;
    p  = (p + 64'd32768) >> 16;
    if (p > 64'd16384) begin
      p = 64'd16384;
    end
    return p[14:0];
  endfunction

endpackage

// ----- hw/rtl/tvg_sine.sv -----
module tvg_sine #(
  parameter int unsigned SINE_ADDR_BITS = 10
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] phase_i,
  output logic [14:0] mag_o,
  output logic        neg_o
);
  import tvg_pkg::*;

  localparam int unsigned ADDR_W    = SINE_ADDR_BITS + 1;
  localparam int unsigned ROM_DEPTH = (1 << SINE_ADDR_BITS) + 1;
  localparam logic [ADDR_W-1:0] QSIZE = ADDR_W'(1 << SINE_ADDR_BITS);

  typedef logic [14:0] rom_t [ROM_DEPTH];

  function automatic rom_t build_rom();
    rom_t t;
    for (int unsigned k = 0; k < ROM_DEPTH; k++) begin
      t[k] = sine_entry(k, SINE_ADDR_BITS);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [SINE_ADDR_BITS-1:0] k_w;
  logic [ADDR_W-1:0]         addr_w;
  logic [14:0]               mag_q;
  logic                      neg_q;

  // Quadrant folding: odd quadrants read mirrored, upper half negates
  assign k_w    = phase_i[13 -: SINE_ADDR_BITS];
  assign addr_w = phase_i[14] ? (QSIZE - {1'b0, k_w}) : {1'b0, k_w};

  // Registered table read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= SINE_ROM[addr_w];
      neg_q <= phase_i[15];
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

// ----- hw/rtl/tvg_vertex.sv -----
module tvg_vertex (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] ct_i,
  input  logic signed [15:0] nst_i,
  input  logic signed [17:0] dist_i,
  input  logic signed [15:0] cp_i,
  input  logic signed [15:0] nsp_i,
  input  logic        [14:0] inner_radius_i,
  output tvg_pkg::vertex_t   vertex_o
);
  import tvg_pkg::*;

  logic signed [33:0] px_q, py_q, pz_q, nx_q, nz_q;
  logic signed [15:0] ny_q;

  // Round to nearest (ties up) from Q28 to Q14, then clamp to 16 bits
  function automatic logic signed [15:0] round_sat(logic signed [33:0] p);
    logic signed [33:0] t;
    logic signed [33:0] s;
    t = p + 34'sd8192;
    s = t >>> 14;
    if (s > 34'sd32767) begin
      return 16'sh7fff;
    end else if (s < -34'sd32768) begin
      return 16'sh8000;
    end
    return s[15:0];
  endfunction

  // Product stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q <= ct_i * dist_i;
      py_q <= nsp_i * $signed({1'b0, inner_radius_i});
      pz_q <= nst_i * dist_i;
      nx_q <= ct_i * cp_i;
      nz_q <= nst_i * cp_i;
      ny_q <= nsp_i;
    end
  end

  always_comb begin
    vertex_o.pos_x  = round_sat(px_q);
    vertex_o.pos_y  = round_sat(py_q);
    vertex_o.pos_z  = round_sat(pz_q);
    vertex_o.norm_x = round_sat(nx_q);
    vertex_o.norm_y = ny_q;
    vertex_o.norm_z = round_sat(nz_q);
  end

endmodule

// ----- hw/rtl/tvg_serializer.sv -----
module tvg_serializer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  tvg_pkg::vertex_t vert0_i,
  input  tvg_pkg::vertex_t vert1_i,
  output logic             valid_o,
  input  logic             ready_i,
  output tvg_pkg::vertex_t vert_o,
  output logic             last_o
);
  import tvg_pkg::*;

  vertex_t vert0_q, vert1_q;
  logic    full_q, sel_q;
  logic    load_w;

  // Slot frees when the second vertex goes out
  assign ready_o = ~full_q | (sel_q & ready_i);
  assign load_w  = valid_i & ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      sel_q  <= 1'b0;
    end else if (load_w) begin
      full_q <= 1'b1;
      sel_q  <= 1'b0;
    end else if (full_q && ready_i) begin
      if (sel_q) begin
        full_q <= 1'b0;
        sel_q  <= 1'b0;
      end else begin
        sel_q <= 1'b1;
      end
    end
  end

  // Pair payload
  always_ff @(posedge clk_i) begin
    if (load_w) begin
      vert0_q <= vert0_i;
      vert1_q <= vert1_i;
    end
  end

  assign valid_o = full_q;
  assign vert_o  = sel_q ? vert1_q : vert0_q;
  assign last_o  = sel_q;

endmodule

// ----- hw/rtl/torus_vertex_generator.sv -----
// Torus vertex generator: one (ring, side) item in, two vertices out.
// The first vertex is offered once the item has passed the five register stages,
// the second as soon as the first is taken. The two vertex transfers per item on
// the single output stream limit the input rate; the 5-stage pipeline itself
// takes an item every cycle when not stalled. Reset (async, active low) clears
// all valid bits and loads the register defaults; the sine table is constant.
module torus_vertex_generator #(
  parameter int unsigned MAX_COUNT      = 256,
  parameter int unsigned SINE_ADDR_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // ring_index[7:0], side_index[16:8], zero pad
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
  output logic        m_axis_tlast
);
  import tvg_pkg::*;

  localparam int unsigned RING_MAX = MAX_COUNT - 1;
  localparam int unsigned SIDE_MAX = MAX_COUNT;

  // Configuration registers
  logic [14:0] inner_q, outer_q;
  logic [15:0] ring_step_q, side_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q     <= 15'd3277;
      outer_q     <= 15'd8192;
      ring_step_q <= 16'd2185;
      side_step_q <= 16'd2185;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INNER_RADIUS:    inner_q     <= cfg_data_i[14:0];
        CFG_OUTER_RADIUS:    outer_q     <= cfg_data_i[14:0];
        CFG_RING_PHASE_STEP: ring_step_q <= cfg_data_i;
        CFG_SIDE_PHASE_STEP: side_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stall chain: a stage loads when empty or when the next one loads
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy4 = ~v4_q | rdy5;
  assign rdy3 = ~v3_q | rdy4;
  assign rdy2 = ~v2_q | rdy3;
  assign rdy1 = ~v1_q | rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: index clamp and phase products
  logic [7:0]  ring_w, ring_sat_w;
  logic [8:0]  side_w, side_sat_w, ring1_w;
  logic [23:0] rp0_full_w;
  logic [24:0] rp1_full_w, sph_full_w;
  logic [15:0] rp0_q, rp1_q, sph_q;

  assign ring_w     = s_axis_tdata[7:0];
  assign side_w     = s_axis_tdata[16:8];
  assign ring_sat_w = (32'(ring_w) > RING_MAX) ? 8'(RING_MAX) : ring_w;
  assign side_sat_w = (32'(side_w) > SIDE_MAX) ? 9'(SIDE_MAX) : side_w;
  assign ring1_w    = {1'b0, ring_sat_w} + 9'd1;
  assign rp0_full_w = 24'(ring_sat_w) * 24'(ring_step_q);
  assign rp1_full_w = 25'(ring1_w) * 25'(ring_step_q);
  assign sph_full_w = 25'(side_sat_w) * 25'(side_step_q);

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      rp0_q <= rp0_full_w[15:0];
      rp1_q <= rp1_full_w[15:0];
      sph_q <= sph_full_w[15:0];
    end
  end

  // Stage 2: six table lookups; cosine is sine a quarter turn ahead
  logic [14:0] cp_mag, sp_mag, ct0_mag, st0_mag, ct1_mag, st1_mag;
  logic        cp_neg, sp_neg, ct0_neg, st0_neg, ct1_neg, st1_neg;

  tvg_sine #(.SINE_ADDR_BITS(SINE_ADDR_BITS)) u_cp (
    .clk_i, .en_i(rdy2), .phase_i(sph_q + 16'h4000), .mag_o(cp_mag), .neg_o(cp_neg)
  );
  tvg_sine #(.SINE_ADDR_BITS(SINE_ADDR_BITS)) u_sp (
    .clk_i, .en_i(rdy2), .phase_i(sph_q), .mag_o(sp_mag), .neg_o(sp_neg)
  );
  tvg_sine #(.SINE_ADDR_BITS(SINE_ADDR_BITS)) u_ct0 (
    .clk_i, .en_i(rdy2), .phase_i(rp0_q + 16'h4000), .mag_o(ct0_mag), .neg_o(ct0_neg)
  );
  tvg_sine #(.SINE_ADDR_BITS(SINE_ADDR_BITS)) u_st0 (
    .clk_i, .en_i(rdy2), .phase_i(rp0_q), .mag_o(st0_mag), .neg_o(st0_neg)
  );
  tvg_sine #(.SINE_ADDR_BITS(SINE_ADDR_BITS)) u_ct1 (
    .clk_i, .en_i(rdy2), .phase_i(rp1_q + 16'h4000), .mag_o(ct1_mag), .neg_o(ct1_neg)
  );
  tvg_sine #(.SINE_ADDR_BITS(SINE_ADDR_BITS)) u_st1 (
    .clk_i, .en_i(rdy2), .phase_i(rp1_q), .mag_o(st1_mag), .neg_o(st1_neg)
  );

  // Stage 3: signed values (sines pre-negated) and ring distance
  logic signed [15:0] cp_w, nsp_w, ct0_w, nst0_w, ct1_w, nst1_w;
  logic signed [15:0] cp_q, nsp_q, ct0_q, nst0_q, ct1_q, nst1_q;
  logic signed [31:0] rcp_w, rcp_sh_w;
  logic signed [17:0] dist_w, dist_q;

  assign cp_w   = cp_neg  ? -$signed({1'b0, cp_mag})  : $signed({1'b0, cp_mag});
  assign nsp_w  = sp_neg  ?  $signed({1'b0, sp_mag})  : -$signed({1'b0, sp_mag});
  assign ct0_w  = ct0_neg ? -$signed({1'b0, ct0_mag}) : $signed({1'b0, ct0_mag});
  assign nst0_w = st0_neg ?  $signed({1'b0, st0_mag}) : -$signed({1'b0, st0_mag});
  assign ct1_w  = ct1_neg ? -$signed({1'b0, ct1_mag}) : $signed({1'b0, ct1_mag});
  assign nst1_w = st1_neg ?  $signed({1'b0, st1_mag}) : -$signed({1'b0, st1_mag});

  assign rcp_w    = $signed({1'b0, inner_q}) * cp_w;
  assign rcp_sh_w = (rcp_w + 32'sd8192) >>> 14;
  assign dist_w   = $signed({3'b000, outer_q}) + $signed(rcp_sh_w[17:0]);

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      cp_q   <= cp_w;
      nsp_q  <= nsp_w;
      ct0_q  <= ct0_w;
      nst0_q <= nst0_w;
      ct1_q  <= ct1_w;
      nst1_q <= nst1_w;
      dist_q <= dist_w;
    end
  end

  // Stage 4: vertex products, rounding and clamp
  vertex_t vert0_w, vert1_w, vert_out_w;

  tvg_vertex u_vert0 (
    .clk_i, .en_i(rdy4), .ct_i(ct0_q), .nst_i(nst0_q), .dist_i(dist_q),
    .cp_i(cp_q), .nsp_i(nsp_q), .inner_radius_i(inner_q), .vertex_o(vert0_w)
  );
  tvg_vertex u_vert1 (
    .clk_i, .en_i(rdy4), .ct_i(ct1_q), .nst_i(nst1_q), .dist_i(dist_q),
    .cp_i(cp_q), .nsp_i(nsp_q), .inner_radius_i(inner_q), .vertex_o(vert1_w)
  );

  // Stage 5: output register, two transfers per item
  tvg_serializer u_ser (
    .clk_i, .rst_ni,
    .valid_i(v4_q), .ready_o(rdy5), .vert0_i(vert0_w), .vert1_i(vert1_w),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .vert_o(vert_out_w),
    .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = vert_out_w;

  // A first vertex is always followed at once by its partner
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
    else $error("second vertex of a pair missing");

  // A stalled stage 1 keeps its item
  a_stage1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !rdy2 |=> v1_q)
    else $error("stage 1 item lost under stall");

  // Nothing appears from an empty pipeline
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q && !v2_q && !v3_q && !v4_q && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("output valid without an item in flight");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tvg_pkg::*;

  localparam int unsigned SINE_BITS = 10;
  localparam int unsigned TAB_SIZE  = 1 << SINE_BITS;
  localparam int unsigned MAX_CNT   = 256;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned SETTLE    = 10;

  // indexes outside the register list, writes there must be ignored
  localparam logic [2:0] CFG_UNUSED_LO = 3'd4;
  localparam logic [2:0] CFG_UNUSED_HI = 3'd7;

  // Taylor terms of sin(pi/2 * x), unsigned Q30
  localparam logic [63:0] TAY1 = 64'd1686629713;
  localparam logic [63:0] TAY3 = 64'd693598669;
  localparam logic [63:0] TAY5 = 64'd85569306;
  localparam logic [63:0] TAY7 = 64'd5026994;
  localparam logic [63:0] TAY9 = 64'd172273;

  typedef struct packed {
    logic [8:0] side;
    logic [7:0] ring;
  } strip_item_t;

  typedef struct {
    vertex_t vtx;
    logic    last;
  } vertex_exp_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_idx_i     = '0;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // ring_index[7:0], side_index[16:8], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;         // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
  logic        m_axis_tlast;

  // shadow copy of the configuration registers
  logic [14:0] tube_r    = 15'd3277;
  logic [14:0] ring_r    = 15'd8192;
  logic [15:0] ring_step = 16'd2185;
  logic [15:0] side_step = 16'd2185;

  longint      sine_tab [0:TAB_SIZE];
  strip_item_t strip_item_q [$];
  vertex_exp_t vertex_expect_q [$];

  int          src_idle_pct   = 0;
  int          snk_stall_pct  = 0;
  logic        long_hold_go   = 1'b0;
  logic        long_hold_done;
  int unsigned hold_left;
  int unsigned err_cnt        = 0;

  torus_vertex_generator u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Vertex prediction
  // ---------------------------------------------------------------------------

  // quarter-wave lookup, phase of 16 bits is one full turn
  function automatic longint sin_q14(logic [15:0] ph);
    int unsigned k;
    longint      v;
    k = int'(ph[13:0]) >> (14 - SINE_BITS);
    v = ph[14] ? sine_tab[TAB_SIZE - k] : sine_tab[k];
    return ph[15] ? -v : v;
  endfunction

  function automatic longint cos_q14(logic [15:0] ph);
    return sin_q14(ph + 16'h4000);
  endfunction

  // Q14 product, round half up
  function automatic longint mul_q14r(longint a, longint b);
    return (a * b + 64'sd8192) >>> 14;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic vertex_t vertex_at(logic [15:0] rp, longint cp, longint sp,
                                        longint ctr_dist);
    vertex_t vx;
    longint  ct;
    longint  st;
    ct = cos_q14(rp);
    st = sin_q14(rp);
    vx.pos_x  = clip16(mul_q14r(ct, ctr_dist));
    vx.pos_y  = clip16(mul_q14r(-sp, longint'(tube_r)));
    vx.pos_z  = clip16(mul_q14r(-st, ctr_dist));
    vx.norm_x = clip16(mul_q14r(ct, cp));
    vx.norm_y = clip16(-sp);
    vx.norm_z = clip16(mul_q14r(-st, cp));
    return vx;
  endfunction

  // both vertices of one strip step: ring i, then ring i+1
  task automatic push_strip_vertices(logic [7:0] ring_in, logic [8:0] side_in);
    int unsigned r;
    int unsigned s;
    logic [15:0] sph;
    longint      cp;
    longint      sp;
    longint      ctr_dist;
    vertex_exp_t e;
    r = (ring_in > MAX_CNT - 1) ? MAX_CNT - 1 : ring_in;
    s = (side_in > MAX_CNT) ? MAX_CNT : side_in;
    sph  = 16'(s * side_step);
    cp   = cos_q14(sph);
    sp   = sin_q14(sph);
    ctr_dist = longint'(ring_r) + mul_q14r(longint'(tube_r), cp);
    e.vtx  = vertex_at(16'(r * ring_step), cp, sp, ctr_dist);
    e.last = 1'b0;
    vertex_expect_q.push_back(e);
    e.vtx  = vertex_at(16'((r + 1) * ring_step), cp, sp, ctr_dist);
    e.last = 1'b1;
    vertex_expect_q.push_back(e);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic check_field(string name, logic signed [15:0] got, logic signed [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // output monitor
  always @(posedge clk_i) begin : mon
    vertex_t     got;
    vertex_exp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (vertex_expect_q.size() == 0) begin
        report_mismatch("vertex transfer with nothing expected");
      end else begin
        want = vertex_expect_q.pop_front();
        check_field("pos_x", got.pos_x, want.vtx.pos_x);
        check_field("pos_y", got.pos_y, want.vtx.pos_y);
        check_field("pos_z", got.pos_z, want.vtx.pos_z);
        check_field("norm_x", got.norm_x, want.vtx.norm_x);
        check_field("norm_y", got.norm_y, want.vtx.norm_y);
        check_field("norm_z", got.norm_z, want.vtx.norm_z);
        check_field("last", 16'(m_axis_tlast), 16'(want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stream drivers
  // ---------------------------------------------------------------------------

  // input driver: offer the next pending item once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin : drv
    strip_item_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        push_strip_vertices(s_axis_tdata[7:0], s_axis_tdata[16:8]);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (strip_item_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          nxt = strip_item_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'd0, nxt};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output ready: random stalls, plus one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready  <= 1'b0;
      hold_left      <= 0;
      long_hold_done <= 1'b0;
    end else if (long_hold_go && !long_hold_done) begin
      m_axis_tready  <= 1'b0;
      hold_left      <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic void queue_item(logic [7:0] ring, logic [8:0] side);
    strip_item_t it;
    it.ring = ring;
    it.side = side;
    strip_item_q.push_back(it);
  endfunction

  // mostly legal side indexes, some past the closing side
  function automatic void queue_random_items(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        queue_item(8'($urandom_range(0, 255)), 9'($urandom_range(MAX_CNT + 1, 511)));
      end else begin
        queue_item(8'($urandom_range(0, 255)), 9'($urandom_range(0, MAX_CNT)));
      end
    end
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_INNER_RADIUS:    tube_r    = val[14:0];
      CFG_OUTER_RADIUS:    ring_r    = val[14:0];
      CFG_RING_PHASE_STEP: ring_step = val;
      CFG_SIDE_PHASE_STEP: side_step = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait until every pending item went in and every vertex came out
  task automatic drain();
    while (strip_item_q.size() != 0 || s_axis_tvalid || vertex_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] p;

    // quarter-wave sine table, Q14
    for (int unsigned k = 0; k <= TAB_SIZE; k++) begin
      u  = 64'(k) << (30 - SINE_BITS);
      u2 = (u * u) >> 30;
      p  = TAY9;
      p  = TAY7 - ((u2 * p) >> 30);
      p  = TAY5 - ((u2 * p) >> 30);
      p  = TAY3 - ((u2 * p) >> 30);
      p  = TAY1 - ((u2 * p) >> 30);
      p  = (u * p) >> 30;
      p  = (p + 64'd32768) >> 16;
      if (p > 64'd16384) begin
        p = 64'd16384;
      end
      sine_tab[k] = longint'(p);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed, reset configuration: index extremes, side clamp, ring wrap
    queue_item(8'd0, 9'd0);
    queue_item(8'd255, 9'd0);
    queue_item(8'd0, 9'd256);
    queue_item(8'd255, 9'd256);
    queue_item(8'd1, 9'd257);
    queue_item(8'd2, 9'd511);
    queue_item(8'd255, 9'd511);
    queue_item(8'd128, 9'd64);
    queue_item(8'd64, 9'd128);
    queue_item(8'd170, 9'd341);
    queue_item(8'd85, 9'd170);
    queue_item(8'd254, 9'd255);
    queue_item(8'd127, 9'd384);
    queue_item(8'd30, 9'd30);
    drain();

    // largest radii and steps: saturation; too-wide data and unused indexes
    write_reg(CFG_INNER_RADIUS, 16'hffff);
    write_reg(CFG_OUTER_RADIUS, 16'hffff);
    write_reg(CFG_RING_PHASE_STEP, 16'hffff);
    write_reg(CFG_SIDE_PHASE_STEP, 16'h4000);
    write_reg(CFG_UNUSED_LO, 16'h0000);
    write_reg(CFG_UNUSED_HI, 16'h1234);
    queue_item(8'd0, 9'd0);
    queue_item(8'd0, 9'd1);
    queue_item(8'd255, 9'd2);
    queue_item(8'd1, 9'd3);
    queue_item(8'd127, 9'd4);
    queue_item(8'd200, 9'd300);
    drain();
    write_reg(CFG_SIDE_PHASE_STEP, 16'hffff);
    src_idle_pct = 85;
    queue_random_items(400);
    drain();

    // all zero: degenerate torus, no rotation
    write_reg(CFG_INNER_RADIUS, 16'h0000);
    write_reg(CFG_OUTER_RADIUS, 16'h0000);
    write_reg(CFG_RING_PHASE_STEP, 16'h0000);
    write_reg(CFG_SIDE_PHASE_STEP, 16'h0000);
    src_idle_pct  = 0;
    snk_stall_pct = 85;
    queue_random_items(400);
    drain();

    // random configurations
    src_idle_pct  = 25;
    snk_stall_pct = 25;
    for (int i = 0; i < 4; i++) begin
      write_reg(CFG_INNER_RADIUS, 16'($urandom));
      write_reg(CFG_OUTER_RADIUS, 16'($urandom));
      write_reg(CFG_RING_PHASE_STEP, 16'($urandom));
      write_reg(CFG_SIDE_PHASE_STEP, 16'($urandom));
      write_reg(3'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)), 16'($urandom));
      queue_random_items(100);
      drain();
    end

    // full rate with one long output hold-off so the pipeline backs up
    write_reg(CFG_INNER_RADIUS, 16'd4915);
    write_reg(CFG_OUTER_RADIUS, 16'd12288);
    write_reg(CFG_RING_PHASE_STEP, 16'd257);
    write_reg(CFG_SIDE_PHASE_STEP, 16'd256);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    long_hold_go  = 1'b1;
    queue_random_items(400);
    drain();

    if (vertex_expect_q.size() != 0) begin
      report_mismatch($sformatf("%0d vertices never arrived", vertex_expect_q.size()));
    end
    if (err_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/tvg_pkg.sv
hw/rtl/tvg_sine.sv
hw/rtl/tvg_vertex.sv
hw/rtl/tvg_serializer.sv
hw/rtl/torus_vertex_generator.sv
tb/tb_top.sv
